>>> sv/julia_escape_time_pixel_macros.svh
// Assertion macros for the escape-time pixel engine
`ifndef JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JET_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define JET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> sv/jetp_pkg.sv
`default_nettype none
package jetp_pkg;
   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
   } req_type;
   typedef struct packed {
      logic [11:0]        iter_count;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic signed [31:0] final_re;
      logic signed [31:0] final_im;
   } rsp_type;
   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
   } point_type;
   typedef enum logic [2:0] {
      CSR_CONST_RE = 3'd0, CSR_CONST_IM = 3'd1, CSR_PIXEL_STEP = 3'd2,
      CSR_CENTER_RE = 3'd3, CSR_CENTER_IM = 3'd4, CSR_ESCAPE_LIMIT = 3'd5,
      CSR_MAX_ITER = 3'd6
   } csr_index_type;
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;
   function automatic color_type gradient(input logic [2:0] k);
      color_type c;
      c = '0;
      case (k)
         3'd0: c = '{8'h51, 8'hE5, 8'hFF};
         3'd1: c = '{8'h4E, 8'hB7, 8'hE5};
         3'd2: c = '{8'h4B, 8'h8A, 8'hCC};
         3'd3: c = '{8'h49, 8'h5D, 8'hB3};
         3'd4: c = '{8'h46, 8'h30, 8'h9A};
         default: c = '{8'h51, 8'hE5, 8'hFF};
      endcase
      return c;
   endfunction
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh80000000) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

>>> sv/jetp_front.sv
`default_nettype none
module jetp_front #(
   parameter int IMAGE_WIDTH  = 1024,
   parameter int IMAGE_HEIGHT = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire jetp_pkg::req_type req_word,
   input  wire logic signed [31:0] pixel_step,
   input  wire logic signed [31:0] center_re,
   input  wire logic signed [31:0] center_im,
   output logic                    pt_valid,
   input  wire logic               pt_ready,
   output jetp_pkg::point_type     pt_word
);
   localparam logic signed [13:0] HALF_W = 14'(IMAGE_WIDTH / 2);
   localparam logic signed [13:0] HALF_H = 14'(IMAGE_HEIGHT / 2);
   logic                   s1_valid_ff, s1_valid_in;
   logic signed [63:0]     pre_ff, pim_ff;
   logic [1:0]             cnt_ff, cnt_in;
   jetp_pkg::point_type    q_ff [2];
   logic                   wr_ff, rd_ff, wr_in, rd_in;
   logic                   push, pop, s1_go;
   logic signed [13:0]     dx, dy;

   assign dx = $signed({4'b0, req_word.pixel_x}) - HALF_W;
   assign dy = HALF_H - $signed({4'b0, req_word.pixel_y});
   assign s1_go = s1_valid_ff && (cnt_ff != 2'd2);
   assign req_ready = !s1_valid_ff || s1_go;
   assign push = s1_go;
   assign pop = pt_valid && pt_ready;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_go);
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign wr_in = push ? !wr_ff : wr_ff;
   assign rd_in = pop ? !rd_ff : rd_ff;
   assign pt_valid = cnt_ff != 2'd0;
   assign pt_word = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cnt_ff <= '0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         cnt_ff <= cnt_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
      if (req_valid && req_ready) begin
         pre_ff <= 64'(dx) * 64'(pixel_step) - 64'(center_re);
         pim_ff <= 64'(dy) * 64'(pixel_step) - 64'(center_im);
      end
      if (push) begin
         q_ff[wr_ff] <= '{jetp_pkg::sat32(pre_ff), jetp_pkg::sat32(pim_ff)};
      end
   end
endmodule
`default_nettype wire

>>> sv/jetp_back.sv
`default_nettype none
`include "julia_escape_time_pixel_macros.svh"
module jetp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pt_valid,
   output logic                     pt_ready,
   input  wire jetp_pkg::point_type pt_word,
   input  wire logic signed [31:0]  const_re,
   input  wire logic signed [31:0]  const_im,
   input  wire logic [39:0]         escape_limit,
   input  wire logic [11:0]         max_iter,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output jetp_pkg::rsp_type        rsp_word
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001, ST_MUL = 3'b010, ST_ADD = 3'b100
   } state_type;
   state_type          st_ff, st_in;
   logic signed [31:0] re_ff, im_ff;
   logic signed [63:0] rr_ff, ii_ff, ri_ff;
   logic [11:0]        k_ff;
   logic [2:0]         m_ff;
   logic               out_v_ff;
   jetp_pkg::rsp_type  out_ff;
   logic [63:0]        norm;
   logic signed [63:0] dre, dim;
   logic               done;
   jetp_pkg::color_type col;

   assign norm = rr_ff + ii_ff;
   assign done = (k_ff == max_iter) || ((norm >> 24) >= {24'b0, escape_limit});
   assign dre = ((rr_ff - ii_ff) >>> 24) + 64'(const_re);
   assign dim = (ri_ff >>> 23) + 64'(const_im);
   assign col = jetp_pkg::gradient(m_ff);
   assign pt_ready = st_ff == ST_IDLE;
   assign rsp_valid = out_v_ff;
   assign rsp_word = out_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (pt_valid) st_in = ST_MUL;
         ST_MUL:  st_in = ST_ADD;
         ST_ADD:  if (done) begin
            if (!out_v_ff || rsp_ready) st_in = ST_IDLE;
         end else st_in = ST_MUL;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_ADD && done && (!out_v_ff || rsp_ready)) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
      unique case (st_ff)
         ST_IDLE: begin
            re_ff <= pt_word.re;
            im_ff <= pt_word.im;
            k_ff <= '0;
            m_ff <= '0;
         end
         ST_MUL: begin
            rr_ff <= 64'(re_ff) * 64'(re_ff);
            ii_ff <= 64'(im_ff) * 64'(im_ff);
            ri_ff <= 64'(re_ff) * 64'(im_ff);
         end
         ST_ADD: if (done) begin
            if (!out_v_ff || rsp_ready)
               out_ff <= '{k_ff, col.red, col.green, col.blue, re_ff, im_ff};
         end else begin
            re_ff <= jetp_pkg::sat32(dre);
            im_ff <= jetp_pkg::sat32(dim);
            k_ff <= k_ff + 12'd1;
            m_ff <= (m_ff == 3'd4) ? 3'd0 : m_ff + 3'd1;
         end
         default: ;
      endcase
   end

   `JET_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(st_ff), "state not one-hot")
   `JET_ASSERT_IMP(a_kmax, clock, reset, st_ff != ST_IDLE, k_ff <= max_iter, "count overrun")
   `JET_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
endmodule
`default_nettype wire

>>> sv/julia_escape_time_pixel.sv
// Julia escape-time pixel engine.
// The front maps each pixel to a point into a queue; the back end loads the
// point, then alternates multiply and add states per squaring step. The back end's
// squaring loop sets the pixel rate, the front maps the next pixels meanwhile.
// Reset: synchronous; control and CSR registers return to defaults, queues empty.
`default_nettype none
module julia_escape_time_pixel #(
   parameter int IMAGE_WIDTH  = 1024,
   parameter int IMAGE_HEIGHT = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire jetp_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output jetp_pkg::rsp_type      rsp_word,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [39:0]       csr_data
);
   logic signed [31:0] const_re_ff, const_im_ff, step_ff, cre_ff, cim_ff;
   logic [39:0]        lim_ff;
   logic [11:0]        max_ff;
   logic               pt_valid, pt_ready;
   jetp_pkg::point_type pt_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         const_re_ff <= '0;
         const_im_ff <= '0;
         step_ff <= 32'sd67109;
         cre_ff <= '0;
         cim_ff <= '0;
         lim_ff <= 40'd67108864;
         max_ff <= 12'd1000;
      end else if (csr_valid) begin
         case (csr_index)
            jetp_pkg::CSR_CONST_RE:     const_re_ff <= csr_data[31:0];
            jetp_pkg::CSR_CONST_IM:     const_im_ff <= csr_data[31:0];
            jetp_pkg::CSR_PIXEL_STEP:   step_ff <= csr_data[31:0];
            jetp_pkg::CSR_CENTER_RE:    cre_ff <= csr_data[31:0];
            jetp_pkg::CSR_CENTER_IM:    cim_ff <= csr_data[31:0];
            jetp_pkg::CSR_ESCAPE_LIMIT: lim_ff <= csr_data;
            jetp_pkg::CSR_MAX_ITER:     max_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   jetp_front #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .pixel_step(step_ff), .center_re(cre_ff), .center_im(cim_ff),
      .pt_valid, .pt_ready, .pt_word
   );

   jetp_back u_back (
      .clock, .reset, .pt_valid, .pt_ready, .pt_word,
      .const_re(const_re_ff), .const_im(const_im_ff),
      .escape_limit(lim_ff), .max_iter(max_ff),
      .rsp_valid, .rsp_ready, .rsp_word
   );
endmodule
`default_nettype wire
